// ----- rtl/bkc_pkg.sv -----
// ---------------------------------------------------------------------------
// BCD keypad calculator package
// Shared types and key codes for the calculator front end and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package bkc_pkg;

    localparam int DISPLAY_W = 32;

    localparam logic [3:0] KEY_ADD    = 4'd10;
    localparam logic [3:0] KEY_SUB    = 4'd11;
    localparam logic [3:0] KEY_MUL    = 4'd12;
    localparam logic [3:0] KEY_DIV    = 4'd13;
    localparam logic [3:0] KEY_EQUALS = 4'd14;
    localparam logic [3:0] KEY_RECALL = 4'd15;
    localparam logic [4:0] NO_KEY     = 5'd16;
    localparam logic [3:0] LAST_DIGIT = 4'd9;

    typedef enum logic [2:0] {
        K_NOP,
        K_DIGIT,
        K_OPER,
        K_EQUALS,
        K_RECALL
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_kind      kind;
        t_op        op;
        logic [3:0] digit;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADD,
        ST_ADD_DONE,
        ST_MUL_SHIFT,
        ST_MUL_CHK,
        ST_DIV_SHIFT,
        ST_RECALL_DATA,
        ST_FINISH,
        ST_REPORT
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/bcd_keypad_calculator_top.sv -----
// A keypad scan goes in and the BCD display after it comes out, one result per
// scan. Scans are queued two deep, so the input takes up to two scans while a command runs.
// Digits, operators, releases and repeats only update the calculator state, and a history
// recall also reads the history RAM. Add, subtract, multiply and divide run on one shared
// digit-serial BCD adder, each pass of which works through DIGIT_COUNT+1 digits; multiply
// repeats the pass for each unit of every multiplier digit, and divide for each trial
// subtraction.
// ---------------------------------------------------------------------------
// BCD keypad calculator top level
// Front end, command queue and digit-serial datapath with history ring.
// ---------------------------------------------------------------------------
`default_nettype none
module bcd_keypad_calculator_top
    import bkc_pkg::*;
#(
    parameter int DIGIT_COUNT   = 8,
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] key_code, [7:4] zero
    input  wire logic        s_axis_tuser,   // [0] key_valid
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] display_digits
    output logic             m_axis_tuser    // [0] divide_error
);

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    bkc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_key_valid (s_axis_tuser),
        .i_key_code  (s_axis_tdata[3:0]),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    bkc_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    bkc_back #(
        .DIGIT_COUNT   (DIGIT_COUNT),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_cmd     (w_head_cmd),
        .o_pop     (w_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_display (m_axis_tdata),
        .o_error   (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ----- rtl/bkc_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module bkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bkc_front.sv -----
// ---------------------------------------------------------------------------
// Calculator front end
// Accepts keypad scans, turns repeats into no-ops and classifies each key.
// ---------------------------------------------------------------------------
`default_nettype none
module bkc_front
    import bkc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_key_valid,
    input  wire logic [3:0] i_key_code,
    input  wire logic       i_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic [4:0] r_prev_key;
    logic [4:0] w_key;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_key   = i_key_valid ? {1'b0, i_key_code} : NO_KEY;

    always_comb begin
        o_cmd.kind  = K_NOP;
        o_cmd.op    = OP_NONE;
        o_cmd.digit = i_key_code;
        // A scan equal to the previous one, or a release, changes nothing.
        if (w_key != r_prev_key && i_key_valid) begin
            case (i_key_code)
                KEY_ADD: begin
                    o_cmd.kind = K_OPER;
                    o_cmd.op   = OP_ADD;
                end
                KEY_SUB: begin
                    o_cmd.kind = K_OPER;
                    o_cmd.op   = OP_SUB;
                end
                KEY_MUL: begin
                    o_cmd.kind = K_OPER;
                    o_cmd.op   = OP_MUL;
                end
                KEY_DIV: begin
                    o_cmd.kind = K_OPER;
                    o_cmd.op   = OP_DIV;
                end
                KEY_EQUALS: o_cmd.kind = K_EQUALS;
                KEY_RECALL: o_cmd.kind = K_RECALL;
                default:    o_cmd.kind = K_DIGIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_key <= NO_KEY;
        end else if (o_push) begin
            r_prev_key <= w_key;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bkc_cmd_fifo.sv -----
// ---------------------------------------------------------------------------
// Command queue
// Two-entry queue of classified commands between front end and datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module bkc_cmd_fifo
    import bkc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("command queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full command queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty command queue");

endmodule
`default_nettype wire

// ----- rtl/bkc_back.sv -----
// ---------------------------------------------------------------------------
// Calculator datapath
// Holds the calculator state and executes commands with a digit-serial
// BCD adder: shift-and-add multiply and restoring long division.
// ---------------------------------------------------------------------------
`default_nettype none
module bkc_back
    import bkc_pkg::*;
#(
    parameter int DIGIT_COUNT   = 8,
    parameter int HISTORY_DEPTH = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_empty,
    input  t_cmd                      i_cmd,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [DISPLAY_W-1:0]      o_display,
    output logic                      o_error
);

    localparam int W    = 4 * DIGIT_COUNT;
    localparam int AW   = W + 4;
    localparam int PW   = $clog2(HISTORY_DEPTH);
    localparam int CW   = $clog2(DIGIT_COUNT + 2);
    localparam int SHOW = (DIGIT_COUNT < 8) ? DIGIT_COUNT : 8;
    localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] ADD_STEPS = CW'(DIGIT_COUNT + 1);
    localparam logic [CW-1:0] DIGITS    = CW'(DIGIT_COUNT);

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_op     r_op, n_op;
    logic [W-1:0]  r_disp, n_disp;
    logic [W-1:0]  r_first, n_first;
    logic [PW-1:0] r_hptr, n_hptr;
    logic [HISTORY_DEPTH-1:0] r_hvalid, n_hvalid;
    logic [AW-1:0] r_x, n_x;
    logic [AW-1:0] r_y, n_y;
    logic [AW-1:0] r_sum, n_sum;
    logic [AW-1:0] r_acc, n_acc;
    logic [W-1:0]  r_mq, n_mq;
    logic [W-1:0]  r_quo, n_quo;
    logic          r_sub, n_sub;
    logic          r_cy, n_cy;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_left, n_left;
    logic [3:0]    r_rep, n_rep;
    logic [3:0]    r_qd, n_qd;
    logic          r_err, n_err;
    logic          r_out_valid, n_out_valid;
    logic [DISPLAY_W-1:0] r_out_data, n_out_data;
    logic          r_out_err, n_out_err;

    logic          w_we;
    logic          w_re;
    logic [PW-1:0] w_raddr;
    logic [W-1:0]  w_rdata;
    logic [3:0]    w_yd;
    logic [4:0]    w_s;
    logic [AW-1:0] w_shift_acc;

    bkc_ram #(
        .WIDTH (W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_hptr),
        .i_wdata (r_acc[W-1:0]),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_valid   = r_out_valid;
    assign o_display = r_out_data;
    assign o_error   = r_out_err;

    // One BCD digit of the running add or subtract.
    assign w_yd = r_sub ? (LAST_DIGIT - r_y[3:0]) : r_y[3:0];
    assign w_s  = {1'b0, r_x[3:0]} + {1'b0, w_yd} + {4'b0, r_cy};
    assign w_shift_acc = {r_acc[W-1:0], r_mq[W-1:W-4]};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_op        = r_op;
        n_disp      = r_disp;
        n_first     = r_first;
        n_hptr      = r_hptr;
        n_hvalid    = r_hvalid;
        n_x         = r_x;
        n_y         = r_y;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_mq        = r_mq;
        n_quo       = r_quo;
        n_sub       = r_sub;
        n_cy        = r_cy;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_rep       = r_rep;
        n_qd        = r_qd;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_out_err   = r_out_err;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = (r_hptr == '0) ? LAST_SLOT : r_hptr - 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (!i_empty && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_err   = 1'b0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_cmd.kind)
                    K_DIGIT: begin
                        n_disp  = {r_disp[W-5:0], r_cmd.digit};
                        n_state = ST_REPORT;
                    end
                    K_OPER: begin
                        n_first = r_disp;
                        n_op    = r_cmd.op;
                        n_disp  = '0;
                        n_state = ST_REPORT;
                    end
                    K_RECALL: begin
                        w_re    = 1'b1;
                        n_hptr  = w_raddr;
                        n_state = ST_RECALL_DATA;
                    end
                    K_EQUALS: begin
                        case (r_op)
                            OP_ADD, OP_SUB: begin
                                n_x     = {4'b0, r_first};
                                n_y     = {4'b0, r_disp};
                                n_sub   = (r_op == OP_SUB);
                                n_cy    = (r_op == OP_SUB);
                                n_cnt   = ADD_STEPS;
                                n_state = ST_ADD;
                            end
                            OP_MUL: begin
                                n_acc   = '0;
                                n_mq    = r_disp;
                                n_left  = DIGITS;
                                n_state = ST_MUL_SHIFT;
                            end
                            OP_DIV: begin
                                if (r_disp == '0) begin
                                    n_acc   = '0;
                                    n_err   = 1'b1;
                                    n_state = ST_FINISH;
                                end else begin
                                    n_acc   = '0;
                                    n_quo   = '0;
                                    n_mq    = r_first;
                                    n_left  = DIGITS;
                                    n_state = ST_DIV_SHIFT;
                                end
                            end
                            default: begin
                                n_acc   = {4'b0, r_first};
                                n_state = ST_FINISH;
                            end
                        endcase
                    end
                    default: n_state = ST_REPORT;
                endcase
            end
            ST_ADD: begin
                n_x   = r_x >> 4;
                n_y   = r_y >> 4;
                n_sum = {(w_s > 5'd9) ? 4'(w_s - 5'd10) : w_s[3:0], r_sum[AW-1:4]};
                n_cy  = (w_s > 5'd9);
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_ADD_DONE;
                end
            end
            ST_ADD_DONE: begin
                case (r_op)
                    OP_MUL: begin
                        n_acc   = {4'b0, r_sum[W-1:0]};
                        n_state = ST_MUL_CHK;
                    end
                    OP_DIV: begin
                        // A final carry means no borrow: the trial subtract fits.
                        if (r_cy) begin
                            n_acc   = r_sum;
                            n_qd    = r_qd + 1'b1;
                            n_x     = r_sum;
                            n_y     = {4'b0, r_disp};
                            n_sub   = 1'b1;
                            n_cy    = 1'b1;
                            n_cnt   = ADD_STEPS;
                            n_state = ST_ADD;
                        end else begin
                            n_quo   = {r_quo[W-5:0], r_qd};
                            n_state = ST_DIV_SHIFT;
                        end
                    end
                    default: begin
                        n_acc   = {4'b0, r_sum[W-1:0]};
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_MUL_SHIFT: begin
                if (r_left == '0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_acc   = {4'b0, r_acc[W-5:0], 4'b0};
                    n_rep   = r_mq[W-1:W-4];
                    n_mq    = {r_mq[W-5:0], 4'b0};
                    n_left  = r_left - 1'b1;
                    n_state = ST_MUL_CHK;
                end
            end
            ST_MUL_CHK: begin
                if (r_rep == '0) begin
                    n_state = ST_MUL_SHIFT;
                end else begin
                    n_rep   = r_rep - 1'b1;
                    n_x     = r_acc;
                    n_y     = {4'b0, r_first};
                    n_sub   = 1'b0;
                    n_cy    = 1'b0;
                    n_cnt   = ADD_STEPS;
                    n_state = ST_ADD;
                end
            end
            ST_DIV_SHIFT: begin
                if (r_left == '0) begin
                    n_acc   = {4'b0, r_quo};
                    n_state = ST_FINISH;
                end else begin
                    // The remainder stays below the divisor, so its top digit is zero.
                    n_acc   = w_shift_acc;
                    n_mq    = {r_mq[W-5:0], 4'b0};
                    n_left  = r_left - 1'b1;
                    n_qd    = '0;
                    n_x     = w_shift_acc;
                    n_y     = {4'b0, r_disp};
                    n_sub   = 1'b1;
                    n_cy    = 1'b1;
                    n_cnt   = ADD_STEPS;
                    n_state = ST_ADD;
                end
            end
            ST_RECALL_DATA: begin
                n_disp  = r_hvalid[r_hptr] ? w_rdata : '0;
                n_state = ST_REPORT;
            end
            ST_FINISH: begin
                w_we             = 1'b1;
                n_disp           = r_acc[W-1:0];
                n_first          = r_acc[W-1:0];
                n_hvalid[r_hptr] = 1'b1;
                n_hptr           = (r_hptr == LAST_SLOT) ? '0 : r_hptr + 1'b1;
                n_state          = ST_REPORT;
            end
            ST_REPORT: begin
                n_out_valid                = 1'b1;
                n_out_data                 = '0;
                n_out_data[4*SHOW-1:0]     = r_disp[4*SHOW-1:0];
                n_out_err                  = r_err;
                n_state                    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_NONE;
            r_disp      <= '0;
            r_first     <= '0;
            r_hptr      <= '0;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
            r_rep       <= '0;
            r_qd        <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_disp      <= n_disp;
            r_first     <= n_first;
            r_hptr      <= n_hptr;
            r_hvalid    <= n_hvalid;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            r_rep       <= n_rep;
            r_qd        <= n_qd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_y        <= n_y;
        r_sum      <= n_sum;
        r_acc      <= n_acc;
        r_mq       <= n_mq;
        r_quo      <= n_quo;
        r_sub      <= n_sub;
        r_cy       <= n_cy;
        r_err      <= n_err;
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid && r_state == ST_IDLE))
        else $error("command taken while a result is pending");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hptr <= LAST_SLOT) else $error("history pointer out of range");
    a_add_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |-> r_cnt != '0) else $error("adder step count is zero");
    a_quot_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD_DONE && r_op == OP_DIV) |-> r_qd <= LAST_DIGIT)
        else $error("quotient digit above nine");

endmodule
`default_nettype wire
